// ===== rtl/lhst_pkg.sv =====
`default_nettype none
package lhst_pkg;

	localparam int OBJ_ID_W   = 16;
	localparam int OBJ_SIZE_W = 32;
	localparam int TOTAL_W    = 48;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_DEATH = 1'b1;

	localparam logic STATUS_APPLIED = 1'b0;
	localparam logic STATUS_IGNORED = 1'b1;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} lhst_state_t;

	typedef struct packed {
		logic busy;
		logic wr_en;
	} lhst_clr_t;

endpackage
`default_nettype wire

// ===== rtl/lhst_evt_if.sv =====
`default_nettype none
interface lhst_evt_if
	import lhst_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic                  command;
	logic [OBJ_ID_W-1:0]   object_key;
	logic [OBJ_SIZE_W-1:0] object_size;

	modport source (output valid, output command, output object_key, output object_size,
		input ready);
	modport sink (input valid, input command, input object_key, input object_size,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/lhst_res_if.sv =====
`default_nettype none
interface lhst_res_if
	import lhst_pkg::*;
;
	logic               valid;
	logic               ready;
	logic [TOTAL_W-1:0] live_bytes;
	logic [TOTAL_W-1:0] peak_bytes;
	logic               status;

	modport source (output valid, output live_bytes, output peak_bytes, output status,
		input ready);
	modport sink (input valid, input live_bytes, input peak_bytes, input status,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/lhst_mem.sv =====
`default_nettype none
module lhst_mem #(
	parameter int ID_BITS   = 16,
	parameter int SIZE_BITS = 32
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [ID_BITS-1:0]   wr_addr,
	input  wire logic [SIZE_BITS:0]   wr_data,
	input  wire logic [ID_BITS-1:0]   rd_addr,
	output logic      [SIZE_BITS:0]   rd_data
);
	localparam int DEPTH = 1 << ID_BITS;

	// entry: live bit on top, recorded size below
	logic [SIZE_BITS:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end
endmodule
`default_nettype wire

// ===== rtl/lhst_clr.sv =====
`default_nettype none
module lhst_clr
	import lhst_pkg::*;
#(
	parameter int ID_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	output lhst_clr_t               ctrl,
	output logic      [ID_BITS-1:0] addr
);
	lhst_state_t        state_q;
	lhst_state_t        state_nxt;
	logic [ID_BITS-1:0] addr_q;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (addr_q == '1) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: state_nxt = ST_RUN;
			default: state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl.busy  = 1'b0;
		ctrl.wr_en = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				ctrl.busy  = 1'b1;
				ctrl.wr_en = 1'b1;
			end
			ST_RUN: begin
				ctrl.busy  = 1'b0;
				ctrl.wr_en = 1'b0;
			end
			default: begin
				ctrl.busy  = 1'b1;
				ctrl.wr_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			addr_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_CLEAR) begin
				addr_q <= addr_q + 1'b1;
			end
		end
	end

	assign addr = addr_q;
endmodule
`default_nettype wire

// ===== rtl/live_heap_size_tracker_top.sv =====
`default_nettype none
// channel | role   | payload
// evt     | sink   | command, object_key, object_size
// res     | source | live_bytes, peak_bytes, status
//
// One event per cycle unless res stalls; results pass the s1 and output registers.
// The table read is registered; a write-back to the id read next is forwarded.
// After reset the table is swept once, every entry cleared, before evt.ready rises.
// A stalled result holds in the output register while the next event is read.
module live_heap_size_tracker_top
	import lhst_pkg::*;
#(
	parameter int ID_BITS   = 16,
	parameter int SIZE_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	lhst_evt_if.sink  evt,
	lhst_res_if.source res
);
	lhst_clr_t            clr;
	logic [ID_BITS-1:0]   clr_addr;

	logic                 v_s1;
	logic                 cmd_s1;
	logic [ID_BITS-1:0]   id_s1;
	logic [SIZE_BITS-1:0] size_s1;

	logic                 fwd_q;
	logic [SIZE_BITS:0]   fwd_word_q;

	logic [TOTAL_W-1:0]   live_q;
	logic [TOTAL_W-1:0]   peak_q;

	logic                 out_valid_q;
	logic [TOTAL_W-1:0]   out_live_q;
	logic [TOTAL_W-1:0]   out_peak_q;
	logic                 out_status_q;

	logic [ID_BITS-1:0]   evt_id;
	logic                 accept;
	logic                 complete;
	logic [SIZE_BITS:0]   mem_rd;
	logic [SIZE_BITS:0]   entry;
	logic                 apply;
	logic [TOTAL_W-1:0]   live_nxt;
	logic [TOTAL_W-1:0]   peak_nxt;
	logic [SIZE_BITS:0]   upd_word;
	logic                 mem_we;
	logic [ID_BITS-1:0]   mem_waddr;
	logic [SIZE_BITS:0]   mem_wdata;
	logic [ID_BITS-1:0]   mem_raddr;

	lhst_clr #(
		.ID_BITS(ID_BITS)
	) u_clr (
		.clk   (clk),
		.arst_n(arst_n),
		.ctrl  (clr),
		.addr  (clr_addr)
	);

	assign evt_id   = ID_BITS'(evt.object_key);
	assign complete = v_s1 && (!out_valid_q || res.ready);
	assign evt.ready = !clr.busy && (!v_s1 || complete);
	assign accept   = evt.valid && evt.ready;

	assign entry = fwd_q ? fwd_word_q : mem_rd;

	always_comb begin
		apply    = 1'b0;
		live_nxt = live_q;
		peak_nxt = peak_q;
		upd_word = entry;
		if (cmd_s1 == CMD_ALLOC) begin
			if (!entry[SIZE_BITS]) begin
				apply    = 1'b1;
				live_nxt = live_q + TOTAL_W'(size_s1);
				upd_word = {1'b1, size_s1};
				if (live_nxt > peak_q) begin
					peak_nxt = live_nxt;
				end
			end
		end else begin
			if (entry[SIZE_BITS]) begin
				apply    = 1'b1;
				live_nxt = live_q - TOTAL_W'(entry[SIZE_BITS-1:0]);
				upd_word = {1'b0, entry[SIZE_BITS-1:0]};
			end
		end
	end

	assign mem_we    = clr.wr_en || (complete && apply);
	assign mem_waddr = clr.wr_en ? clr_addr : id_s1;
	assign mem_wdata = clr.wr_en ? '0 : upd_word;
	assign mem_raddr = accept ? evt_id : id_s1;

	lhst_mem #(
		.ID_BITS  (ID_BITS),
		.SIZE_BITS(SIZE_BITS)
	) u_mem (
		.clk    (clk),
		.wr_en  (mem_we),
		.wr_addr(mem_waddr),
		.wr_data(mem_wdata),
		.rd_addr(mem_raddr),
		.rd_data(mem_rd)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= evt.command;
			id_s1   <= evt_id;
			size_s1 <= SIZE_BITS'(evt.object_size);
		end
		fwd_word_q <= upd_word;
		if (complete) begin
			out_live_q   <= live_nxt;
			out_peak_q   <= peak_nxt;
			out_status_q <= apply ? STATUS_APPLIED : STATUS_IGNORED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			fwd_q       <= 1'b0;
			live_q      <= '0;
			peak_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (complete) begin
				v_s1 <= 1'b0;
			end
			// bypass the write landing in the same cycle as the read of that id
			fwd_q <= accept && complete && apply && (evt_id == id_s1);
			if (complete) begin
				live_q <= live_nxt;
				peak_q <= peak_nxt;
			end
			if (complete) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res.valid      = out_valid_q;
	assign res.live_bytes = out_live_q;
	assign res.peak_bytes = out_peak_q;
	assign res.status     = out_status_q;
endmodule
`default_nettype wire

// ===== rtl/lhst_checker.sv =====
`default_nettype none
module lhst_checker
	import lhst_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire logic [TOTAL_W-1:0] out_live,
	input wire logic [TOTAL_W-1:0] out_peak,
	input wire logic               out_status
);
	logic [TOTAL_W-1:0] last_live_q;
	logic [TOTAL_W-1:0] last_peak_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_live_q <= '0;
			last_peak_q <= '0;
		end else if (out_valid && out_ready) begin
			last_live_q <= out_live;
			last_peak_q <= out_peak;
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_live) && $stable(out_peak))
		else $error("stalled result changed");

	a_peak_above_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_peak >= out_live)
		else $error("peak below live total");

	a_peak_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_peak >= last_peak_q)
		else $error("peak decreased");

	a_ignored_keeps_live: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status == STATUS_IGNORED) |-> out_live == last_live_q)
		else $error("ignored event changed live total");
endmodule

bind live_heap_size_tracker_top lhst_checker u_lhst_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (res.valid),
	.out_ready (res.ready),
	.out_live  (res.live_bytes),
	.out_peak  (res.peak_bytes),
	.out_status(res.status)
);
`default_nettype wire
